FILE: src/svpwm3_pkg.sv
// shared constants, codes and helpers for the three-level svpwm compare generator
package svpwm3_pkg;

  // fractional bits of the normalized dwell times
  localparam int ANGLE_ITER = 16;

  // sqrt(3) in q16
  localparam logic signed [18:0] SQRT3_Q = 19'sd113512;

  // line projection width (signed) and scaled projection width (signed)
  localparam int LW = 34;
  localparam int MW = 52;

  // restoring divider: quotient, numerator, divisor and compare widths
  localparam int DIV_QW = ANGLE_ITER + 3;
  localparam int DIV_NW = (ANGLE_ITER > 17) ? ANGLE_ITER + 35 : 52;
  localparam int DIV_DW = (ANGLE_ITER < 16) ? 48 - ANGLE_ITER : 32;
  localparam int DIV_CW = DIV_NW + DIV_DW;

  // signed dwell time width, unsigned instant width
  localparam int TW = ANGLE_ITER + 4;
  localparam int IW = ANGLE_ITER + 3;

  // square root: one result bit per stage
  localparam int SQ_STEPS = 32;

  // configuration register indexes
  localparam logic CFG_SAMPLE_PERIOD = 1'b0;
  localparam logic CFG_SWITCH_PERIOD = 1'b1;

  // big sector and small region codes
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;
  localparam logic [2:0] SECTOR_6 = 3'd6;

  localparam logic [2:0] REGION_1 = 3'd1;
  localparam logic [2:0] REGION_2 = 3'd2;
  localparam logic [2:0] REGION_3 = 3'd3;
  localparam logic [2:0] REGION_4 = 3'd4;
  localparam logic [2:0] REGION_5 = 3'd5;
  localparam logic [2:0] REGION_6 = 3'd6;

  // sign pattern of the three line projections to big sector
  function automatic logic [2:0] sector_of_flag(input logic [2:0] flag);
    logic [2:0] s;
    case (flag)
      3'd1: s = SECTOR_1;
      3'd3: s = SECTOR_2;
      3'd2: s = SECTOR_3;
      3'd6: s = SECTOR_4;
      3'd4: s = SECTOR_5;
      3'd5: s = SECTOR_6;
      default: s = SECTOR_1;
    endcase
    return s;
  endfunction

endpackage

FILE: src/svpwm3_div.sv
// pipelined restoring divider, one quotient bit per stage
module svpwm3_div import svpwm3_pkg::*; (
  input  logic              clk,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_QW-1:0] quo
);

  logic [DIV_NW-1:0] rem_r [DIV_QW];
  logic [DIV_DW-1:0] den_r [DIV_QW];
  logic [DIV_QW-1:0] quo_r [DIV_QW];

  for (genvar j = 0; j < DIV_QW; j++) begin : g_stage
    logic [DIV_NW-1:0] rem_in;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_QW-1:0] quo_in;
    logic [DIV_CW-1:0] trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign quo_in = quo_r[j-1];
    end

    // quotient bit DIV_QW-1-j
    assign trial = DIV_CW'(den_in) << (DIV_QW - 1 - j);
    assign ge    = DIV_CW'(rem_in) >= trial;

    always_ff @(posedge clk) begin
      rem_r[j] <= ge ? (rem_in - trial[DIV_NW-1:0]) : rem_in;
      den_r[j] <= den_in;
      quo_r[j] <= quo_in | (ge ? (DIV_QW'(1) << (DIV_QW - 1 - j)) : '0);
    end
  end

  assign quo = quo_r[DIV_QW-1];

endmodule

FILE: src/three_level_svpwm_compare_gen_core.sv
// three-level npc svpwm compare generator, fully pipelined
//
//  channel   | ports                                           | handshake
//  ----------+-------------------------------------------------+------------------------
//  command   | alpha_ref, beta_ref, bus_voltage                | start & !busy
//  result    | cmp_a..cmp_f, big_sector, small_region          | done, one cycle
//  config    | wr_index, wr_data                               | wr_en
//
// a word enters every cycle; busy is always low. each word passes from accept to done
// through the 32-stage square root and then two ranks of three 19-stage dividers. a word
// with zero bus voltage gives no done. rst is synchronous, clears the valid bits and
// sets the switch period register to 5000. the receiver cannot stall, so the pipeline
// never holds.
module three_level_svpwm_compare_gen_core import svpwm3_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] alpha_ref,
  input  logic signed [15:0] beta_ref,
  input  logic        [14:0] bus_voltage,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic        [15:0] wr_data,
  output logic               done,
  output logic        [15:0] cmp_a,
  output logic        [15:0] cmp_b,
  output logic        [15:0] cmp_c,
  output logic        [15:0] cmp_d,
  output logic        [15:0] cmp_e,
  output logic        [15:0] cmp_f,
  output logic        [2:0]  big_sector,
  output logic        [2:0]  small_region
);

  localparam int SIDE1_LEN = SQ_STEPS - 3;
  localparam logic [IW-1:0] ONE_U  = IW'(1) << ANGLE_ITER;
  localparam logic [IW-1:0] FULL_U = IW'(1) << (ANGLE_ITER + 2);

  typedef struct packed {
    logic [2:0]        sector;
    logic [2:0]        region;
    logic              clamp;
    logic [14:0]       udc;
    logic [DIV_NW-1:0] num0;
    logic [DIV_NW-1:0] num1;
    logic [DIV_NW-1:0] num2;
  } side1_t;

  typedef struct packed {
    logic [2:0] sector;
    logic [2:0] region;
  } side2_t;

  typedef struct packed {
    logic [2:0]    sector;
    logic [2:0]    region;
    logic          big;
    logic [TW-2:0] t0;
    logic [TW-2:0] t1;
    logic [TW-2:0] t2;
  } side3_t;

  // the sample period is not used, so its value is not kept
  logic [15:0] switch_period_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_period_count <= 16'd5000;
    end else if (wr_en && wr_index == CFG_SWITCH_PERIOD) begin
      switch_period_count <= wr_data;
    end
  end

  assign busy = 1'b0;

  // stage 1: products
  logic signed [31:0] aa_w, bb_w;
  logic        [29:0] uu_w;
  logic signed [LW-1:0] ral_w;

  assign aa_w  = alpha_ref * alpha_ref;
  assign bb_w  = beta_ref * beta_ref;
  assign uu_w  = bus_voltage * bus_voltage;
  assign ral_w = SQRT3_Q * alpha_ref;

  logic                 s1_valid;
  logic signed [15:0]   s1_be;
  logic        [14:0]   s1_udc;
  logic signed [LW-1:0] s1_ral;
  logic        [30:0]   s1_aa, s1_bb;
  logic        [29:0]   s1_uu;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && (bus_voltage != '0);
    end
    s1_be  <= beta_ref;
    s1_udc <= bus_voltage;
    s1_ral <= ral_w;
    s1_aa  <= aa_w[30:0];
    s1_bb  <= bb_w[30:0];
    s1_uu  <= uu_w;
  end

  // stage 2: line projections, sector, clamp decision
  logic signed [LW-1:0] be16_w, l1_w, u3_w;
  logic        [31:0]   ssum_w;
  logic        [33:0]   ssum3_w;

  assign be16_w  = LW'(s1_be) <<< 16;
  assign l1_w    = be16_w - s1_ral;
  assign u3_w    = be16_w + s1_ral;
  assign ssum_w  = 32'(s1_aa) + 32'(s1_bb);
  assign ssum3_w = {1'b0, ssum_w, 1'b0} + 34'(ssum_w);

  logic                 s2_valid;
  logic signed [LW-1:0] s2_l0, s2_l1, s2_l2;
  logic        [31:0]   s2_sum;
  logic                 s2_clamp;
  logic        [2:0]    s2_sector;
  logic        [14:0]   s2_udc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_l0     <= be16_w <<< 1;
    s2_l1     <= l1_w;
    s2_l2     <= -u3_w;
    s2_sum    <= ssum_w;
    s2_clamp  <= ssum3_w > 34'(s1_uu);
    s2_sector <= sector_of_flag({s1_be < 0, l1_w > 0, u3_w > 0});
    s2_udc    <= s1_udc;
  end

  // stage 3: rotate projections into the sector frame
  logic signed [LW-1:0] q0_w, q1_w, q2_w;

  always_comb begin
    case (s2_sector)
      SECTOR_2: begin q0_w = s2_l1;  q1_w = -s2_l2; q2_w = s2_l0;  end
      SECTOR_3: begin q0_w = s2_l2;  q1_w = s2_l0;  q2_w = s2_l1;  end
      SECTOR_4: begin q0_w = -s2_l0; q1_w = s2_l1;  q2_w = s2_l2;  end
      SECTOR_5: begin q0_w = -s2_l1; q1_w = s2_l2;  q2_w = -s2_l0; end
      SECTOR_6: begin q0_w = -s2_l2; q1_w = -s2_l0; q2_w = -s2_l1; end
      default:  begin q0_w = s2_l0;  q1_w = -s2_l1; q2_w = -s2_l2; end
    endcase
  end

  logic                 s3_valid;
  logic signed [LW-1:0] s3_q [3];
  logic                 s3_clamp;
  logic        [2:0]    s3_sector;
  logic        [14:0]   s3_udc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_q[0]   <= q0_w;
    s3_q[1]   <= q1_w;
    s3_q[2]   <= q2_w;
    s3_clamp  <= s2_clamp;
    s3_sector <= s2_sector;
    s3_udc    <= s2_udc;
  end

  // square root of sum << 32, runs beside stages 3 to 34
  logic [33:0] sq_rem  [SQ_STEPS];
  logic [31:0] sq_root [SQ_STEPS];
  logic [63:0] sq_x    [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] x_in;
    logic [35:0] cur, trial;
    logic        ge;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = {s2_sum, 32'd0};
    end else begin : g_next
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
      assign x_in    = sq_x[j-1];
    end

    assign cur   = {rem_in, x_in[63:62]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      sq_rem[j]  <= ge ? 34'(cur - trial) : cur[33:0];
      sq_root[j] <= {root_in[30:0], ge};
      sq_x[j]    <= x_in << 2;
    end
  end

  // stage 4: scale by sqrt3
  logic signed [MW-1:0] m_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_scale
    assign m_w[i] = SQRT3_Q * s3_q[i];
  end

  logic                 s4_valid;
  logic signed [LW-1:0] s4_q [3];
  logic signed [MW-1:0] s4_m [3];
  logic                 s4_low;
  logic                 s4_clamp;
  logic        [2:0]    s4_sector;
  logic        [14:0]   s4_udc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s4_q[i] <= s3_q[i];
      s4_m[i] <= m_w[i];
    end
    s4_low    <= s3_q[0] <= s3_q[1];
    s4_clamp  <= s3_clamp;
    s4_sector <= s3_sector;
    s4_udc    <= s3_udc;
  end

  // stage 5: region and dividend
  logic signed [MW-1:0] bigu_w;
  logic        [2:0]    region_w;
  logic [DIV_NW-1:0]    num_w [3];

  assign bigu_w = $signed({{(MW - 47){1'b0}}, s4_udc, 32'd0});

  always_comb begin
    if (s4_low) begin
      if (s4_m[2] <= bigu_w) begin
        region_w = REGION_1;
      end else if (s4_m[1] >= bigu_w) begin
        region_w = REGION_5;
      end else begin
        region_w = REGION_4;
      end
    end else begin
      if (s4_m[2] <= bigu_w) begin
        region_w = REGION_2;
      end else if (s4_m[0] >= bigu_w) begin
        region_w = REGION_6;
      end else begin
        region_w = REGION_3;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_num
    logic [LW-2:0] qpos;
    logic [MW-2:0] mpos;
    assign qpos     = s4_q[i][LW-1] ? '0 : s4_q[i][LW-2:0];
    assign mpos     = s4_m[i][MW-1] ? '0 : s4_m[i][MW-2:0];
    assign num_w[i] = s4_clamp ? (DIV_NW'(qpos) << ANGLE_ITER) : DIV_NW'(mpos);
  end

  // side data waits for the square root
  logic   sd1_valid [SIDE1_LEN + 1];
  side1_t sd1       [SIDE1_LEN + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SIDE1_LEN; k++) sd1_valid[k] <= 1'b0;
    end else begin
      sd1_valid[0] <= s4_valid;
      for (int k = 1; k <= SIDE1_LEN; k++) sd1_valid[k] <= sd1_valid[k-1];
    end
    sd1[0] <= '{sector: s4_sector, region: region_w, clamp: s4_clamp, udc: s4_udc,
                num0: num_w[0], num1: num_w[1], num2: num_w[2]};
    for (int k = 1; k <= SIDE1_LEN; k++) sd1[k] <= sd1[k-1];
  end

  // stage 35: divisor
  side1_t      sd1_last;
  logic [31:0] root_w;

  assign sd1_last = sd1[SIDE1_LEN];
  assign root_w   = sq_root[SQ_STEPS-1];

  logic              s35_valid;
  logic [DIV_NW-1:0] s35_num [3];
  logic [DIV_DW-1:0] s35_den;
  side2_t            s35_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s35_valid <= 1'b0;
    end else begin
      s35_valid <= sd1_valid[SIDE1_LEN];
    end
    s35_num[0] <= sd1_last.num0;
    s35_num[1] <= sd1_last.num1;
    s35_num[2] <= sd1_last.num2;
    if (sd1_last.clamp) begin
      s35_den <= (root_w == '0) ? DIV_DW'(1) : DIV_DW'(root_w);
    end else begin
      s35_den <= DIV_DW'(sd1_last.udc) << (32 - ANGLE_ITER);
    end
    s35_side <= '{sector: sd1_last.sector, region: sd1_last.region};
  end

  // normalized projections g
  logic [DIV_QW-1:0] g_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_div1
    svpwm3_div u_div (
      .clk (clk),
      .num (s35_num[i]),
      .den (s35_den),
      .quo (g_w[i])
    );
  end

  logic   sd2_valid [DIV_QW];
  side2_t sd2       [DIV_QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_QW; k++) sd2_valid[k] <= 1'b0;
    end else begin
      sd2_valid[0] <= s35_valid;
      for (int k = 1; k < DIV_QW; k++) sd2_valid[k] <= sd2_valid[k-1];
    end
    sd2[0] <= s35_side;
    for (int k = 1; k < DIV_QW; k++) sd2[k] <= sd2[k-1];
  end

  // stage 55: dwell times
  side2_t             sd2_last;
  logic signed [TW-1:0] gs0, gs1, gs2, one_s, two_s;
  logic signed [TW-1:0] tr_w [3];
  logic        [TW-2:0] tc_w [3];

  assign sd2_last = sd2[DIV_QW-1];
  assign gs0   = $signed(TW'(g_w[0]));
  assign gs1   = $signed(TW'(g_w[1]));
  assign gs2   = $signed(TW'(g_w[2]));
  assign one_s = $signed(TW'(ONE_U));
  assign two_s = one_s <<< 1;

  always_comb begin
    case (sd2_last.region)
      REGION_1: begin tr_w[0] = gs1;         tr_w[1] = gs0;         tr_w[2] = one_s - gs2; end
      REGION_2: begin tr_w[0] = gs0;         tr_w[1] = one_s - gs2; tr_w[2] = gs1;         end
      REGION_3: begin tr_w[0] = one_s - gs0; tr_w[1] = one_s - gs1; tr_w[2] = gs2 - one_s; end
      REGION_4: begin tr_w[0] = one_s - gs1; tr_w[1] = gs2 - one_s; tr_w[2] = one_s - gs0; end
      REGION_5: begin tr_w[0] = two_s - gs2; tr_w[1] = gs1 - one_s; tr_w[2] = gs0;         end
      default:  begin tr_w[0] = two_s - gs2; tr_w[1] = gs1;         tr_w[2] = gs0 - one_s; end
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_tclip
    assign tc_w[i] = tr_w[i][TW-1] ? '0 : tr_w[i][TW-2:0];
  end

  logic              s55_valid;
  logic [TW-2:0]     s55_t [3];
  logic [TW+1:0]     s55_sum;
  side2_t            s55_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s55_valid <= 1'b0;
    end else begin
      s55_valid <= sd2_valid[DIV_QW-1];
    end
    for (int i = 0; i < 3; i++) s55_t[i] <= tc_w[i];
    s55_sum  <= (TW+2)'(tc_w[0]) + (TW+2)'(tc_w[1]) + (TW+2)'(tc_w[2]);
    s55_side <= sd2_last;
  end

  // renormalize when the times overrun the period
  logic [DIV_QW-1:0] tn_w [3];

  for (genvar i = 0; i < 3; i++) begin : g_div2
    svpwm3_div u_div (
      .clk (clk),
      .num (DIV_NW'(s55_t[i]) << ANGLE_ITER),
      .den (DIV_DW'(s55_sum)),
      .quo (tn_w[i])
    );
  end

  logic   sd3_valid [DIV_QW];
  side3_t sd3       [DIV_QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_QW; k++) sd3_valid[k] <= 1'b0;
    end else begin
      sd3_valid[0] <= s55_valid;
      for (int k = 1; k < DIV_QW; k++) sd3_valid[k] <= sd3_valid[k-1];
    end
    sd3[0] <= '{sector: s55_side.sector, region: s55_side.region,
                big: s55_sum > (TW+2)'(ONE_U),
                t0: s55_t[0], t1: s55_t[1], t2: s55_t[2]};
    for (int k = 1; k < DIV_QW; k++) sd3[k] <= sd3[k-1];
  end

  // stage 75: switching instants in quarter-period units
  side3_t          sd3_last;
  logic [TW-1:0]   tf_w [3];
  logic [IW-1:0]   tk_w [3];
  logic [IW:0]     ta_w, tb_w, tc4_w;

  assign sd3_last = sd3[DIV_QW-1];
  assign tf_w[0]  = sd3_last.big ? TW'(tn_w[0]) : TW'(sd3_last.t0);
  assign tf_w[1]  = sd3_last.big ? TW'(tn_w[1]) : TW'(sd3_last.t1);
  assign tf_w[2]  = sd3_last.big ? TW'(tn_w[2]) : TW'(sd3_last.t2);

  for (genvar i = 0; i < 3; i++) begin : g_one
    assign tk_w[i] = (tf_w[i] > TW'(ONE_U)) ? ONE_U : tf_w[i][IW-1:0];
  end

  assign ta_w  = (IW+1)'(tk_w[0]);
  assign tb_w  = ta_w + ((IW+1)'(tk_w[1]) << 1);
  assign tc4_w = tb_w + ((IW+1)'(tk_w[2]) << 1);

  logic          s75_valid;
  logic [IW-1:0] s75_i [3];
  side2_t        s75_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s75_valid <= 1'b0;
    end else begin
      s75_valid <= sd3_valid[DIV_QW-1];
    end
    s75_i[0] <= (ta_w  > (IW+1)'(FULL_U)) ? FULL_U : ta_w[IW-1:0];
    s75_i[1] <= (tb_w  > (IW+1)'(FULL_U)) ? FULL_U : tb_w[IW-1:0];
    s75_i[2] <= (tc4_w > (IW+1)'(FULL_U)) ? FULL_U : tc4_w[IW-1:0];
    s75_side <= '{sector: sd3_last.sector, region: sd3_last.region};
  end

  // stage 76: scale by the counter top
  logic             s76_valid;
  logic [IW+15:0]   s76_p [3];
  side2_t           s76_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s76_valid <= 1'b0;
    end else begin
      s76_valid <= s75_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s76_p[i] <= (IW+16)'(s75_i[i]) * (IW+16)'(switch_period_count);
    end
    s76_side <= s75_side;
  end

  // stage 77: per-sector compare arrangement
  logic [15:0] c0_w, c1_w, c2_w;

  assign c0_w = s76_p[0][ANGLE_ITER+2 +: 16];
  assign c1_w = s76_p[1][ANGLE_ITER+2 +: 16];
  assign c2_w = s76_p[2][ANGLE_ITER+2 +: 16];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s76_valid;
    end
    big_sector   <= s76_side.sector;
    small_region <= s76_side.region;
    case (s76_side.sector)
      SECTOR_2: begin
        cmp_a <= c0_w; cmp_b <= c2_w; cmp_c <= c1_w;
        cmp_d <= '0;   cmp_e <= '0;   cmp_f <= c0_w;
      end
      SECTOR_3: begin
        cmp_a <= c0_w; cmp_b <= c1_w; cmp_c <= c2_w;
        cmp_d <= '0;   cmp_e <= '0;   cmp_f <= c0_w;
      end
      SECTOR_4: begin
        cmp_a <= c1_w; cmp_b <= c0_w; cmp_c <= c2_w;
        cmp_d <= switch_period_count; cmp_e <= switch_period_count; cmp_f <= c2_w;
      end
      SECTOR_5: begin
        cmp_a <= c1_w; cmp_b <= c2_w; cmp_c <= c0_w;
        cmp_d <= switch_period_count; cmp_e <= c2_w; cmp_f <= c1_w;
      end
      SECTOR_6: begin
        cmp_a <= c2_w; cmp_b <= c0_w; cmp_c <= c1_w;
        cmp_d <= switch_period_count; cmp_e <= c2_w; cmp_f <= c1_w;
      end
      default: begin
        cmp_a <= c2_w; cmp_b <= c1_w; cmp_c <= c0_w;
        cmp_d <= '0;   cmp_e <= c0_w; cmp_f <= c1_w;
      end
    endcase
  end

endmodule

FILE: tb/tb_three_level_svpwm_compare_gen_core.sv
// testbench for the three-level svpwm compare generator: random and directed words, self-checked
`timescale 1ns / 1ps

module tb_three_level_svpwm_compare_gen_core import svpwm3_pkg::*; ();

  localparam int  FRAC       = 16;
  localparam int  LATENCY    = 77;
  localparam longint LIMIT   = 3000000;
  localparam longint R_SQRT3 = 113512;

  typedef struct packed {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic        [14:0] udc;
  } ref_word_t;

  typedef struct packed {
    logic [15:0] a, b, c, d, e, f;
    logic [2:0]  sector;
    logic [2:0]  region;
  } cmp_word_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] alpha_ref = '0;
  logic signed [15:0] beta_ref = '0;
  logic        [14:0] bus_voltage = '0;
  logic               wr_en = 1'b0;
  logic               wr_index = CFG_SAMPLE_PERIOD;
  logic        [15:0] wr_data = '0;
  logic               done;
  logic        [15:0] cmp_a, cmp_b, cmp_c, cmp_d, cmp_e, cmp_f;
  logic        [2:0]  big_sector, small_region;

  ref_word_t   pending_words[$];
  cmp_word_t   expected_cmps[$];
  logic [15:0] period_top = 16'd5000;
  int          gap_left = 0;
  bit          no_gaps = 1'b0;
  int          errors = 0;
  longint      cycles = 0;

  three_level_svpwm_compare_gen_core u_top (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [15:0] instant_to_cmp(input longint t4, input logic [15:0] per);
    longint full4;
    full4 = longint'(4) << FRAC;
    if (t4 < 0) t4 = 0;
    if (t4 > full4) t4 = full4;
    return 16'((t4 * longint'(per)) / full4);
  endfunction

  // returns 0 when the word makes no result
  function automatic bit predict_compares(input ref_word_t w, input logic [15:0] per,
                                          output cmp_word_t r);
    longint al, be, udc, one, big_u, sum, ta4, tb4, tc4, div;
    longint proj[6], q[3], m[3], g[3], t[3];
    longint unsigned mag;
    logic [2:0] flag, sec, reg_n;
    logic [15:0] c0, c1, c2;
    al = w.alpha;
    be = w.beta;
    udc = w.udc;
    one = longint'(1) << FRAC;
    r = '0;
    if (udc == 0) return 1'b0;
    proj[0] = be * 131072;
    proj[1] = be * 65536 - R_SQRT3 * al;
    proj[2] = -(be * 65536 + R_SQRT3 * al);
    proj[3] = -proj[0];
    proj[4] = -proj[1];
    proj[5] = -proj[2];
    flag = {(-be > 0), (proj[1] > 0), (-proj[2] > 0)};
    case (flag)
      3'd3:    sec = SECTOR_2;
      3'd2:    sec = SECTOR_3;
      3'd6:    sec = SECTOR_4;
      3'd4:    sec = SECTOR_5;
      3'd5:    sec = SECTOR_6;
      default: sec = SECTOR_1;
    endcase
    q[0] = proj[(sec - 1) % 6];
    q[1] = -proj[sec % 6];
    q[2] = proj[(sec + 4) % 6];
    big_u = udc << 32;
    for (int i = 0; i < 3; i++) m[i] = R_SQRT3 * q[i];
    if (q[0] <= q[1]) begin
      if (m[2] <= big_u) reg_n = REGION_1;
      else if (m[1] >= big_u) reg_n = REGION_5;
      else reg_n = REGION_4;
    end else begin
      if (m[2] <= big_u) reg_n = REGION_2;
      else if (m[0] >= big_u) reg_n = REGION_6;
      else reg_n = REGION_3;
    end
    // overmodulation: normalize to the vector length instead of the bus
    if (3 * (al * al + be * be) > udc * udc) begin
      mag = int_sqrt(longint'(al * al + be * be) << 32);
      if (mag == 0) mag = 1;
      for (int i = 0; i < 3; i++)
        g[i] = ((q[i] < 0 ? longint'(0) : q[i]) << FRAC) / longint'(mag);
    end else begin
      div = udc << (32 - FRAC);
      for (int i = 0; i < 3; i++) g[i] = (m[i] < 0 ? 0 : m[i]) / div;
    end
    case (reg_n)
      REGION_1: begin t[0] = g[1];          t[1] = g[0];        t[2] = one - g[2]; end
      REGION_2: begin t[0] = g[0];          t[1] = one - g[2];  t[2] = g[1];       end
      REGION_3: begin t[0] = one - g[0];    t[1] = one - g[1];  t[2] = g[2] - one; end
      REGION_4: begin t[0] = one - g[1];    t[1] = g[2] - one;  t[2] = one - g[0]; end
      REGION_5: begin t[0] = 2 * one - g[2]; t[1] = g[1] - one; t[2] = g[0];       end
      default:  begin t[0] = 2 * one - g[2]; t[1] = g[1];       t[2] = g[0] - one; end
    endcase
    for (int i = 0; i < 3; i++) if (t[i] < 0) t[i] = 0;
    sum = t[0] + t[1] + t[2];
    if (sum > one) for (int i = 0; i < 3; i++) t[i] = t[i] * one / sum;
    for (int i = 0; i < 3; i++) if (t[i] > one) t[i] = one;
    ta4 = t[0];
    tb4 = ta4 + 2 * t[1];
    tc4 = tb4 + 2 * t[2];
    c0 = instant_to_cmp(ta4, per);
    c1 = instant_to_cmp(tb4, per);
    c2 = instant_to_cmp(tc4, per);
    case (sec)
      SECTOR_1: r = '{c2, c1, c0, 16'd0, c0, c1, sec, reg_n};
      SECTOR_2: r = '{c0, c2, c1, 16'd0, 16'd0, c0, sec, reg_n};
      SECTOR_3: r = '{c0, c1, c2, 16'd0, 16'd0, c0, sec, reg_n};
      SECTOR_4: r = '{c1, c0, c2, per, per, c2, sec, reg_n};
      SECTOR_5: r = '{c1, c2, c0, per, c2, c1, sec, reg_n};
      default:  r = '{c2, c0, c1, per, c2, c1, sec, reg_n};
    endcase
    return 1'b1;
  endfunction

  // command driver
  always @(posedge clk) begin
    cmp_word_t r;
    ref_word_t w;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (predict_compares('{alpha_ref, beta_ref, bus_voltage}, period_top, r))
          expected_cmps.push_back(r);
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        alpha_ref <= w.alpha;
        beta_ref <= w.beta;
        bus_voltage <= w.udc;
        start <= 1'b1;
        if (no_gaps) gap_left = 0;
        else if ($urandom_range(0, 9) < 7) gap_left = $urandom_range(0, 2);
        else gap_left = $urandom_range(5, 60);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cmp_word_t x;
    if (!rst && done) begin
      if (expected_cmps.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        x = expected_cmps.pop_front();
        if (cmp_a !== x.a) begin $error("cmp_a exp %0d got %0d", x.a, cmp_a); errors++; end
        if (cmp_b !== x.b) begin $error("cmp_b exp %0d got %0d", x.b, cmp_b); errors++; end
        if (cmp_c !== x.c) begin $error("cmp_c exp %0d got %0d", x.c, cmp_c); errors++; end
        if (cmp_d !== x.d) begin $error("cmp_d exp %0d got %0d", x.d, cmp_d); errors++; end
        if (cmp_e !== x.e) begin $error("cmp_e exp %0d got %0d", x.e, cmp_e); errors++; end
        if (cmp_f !== x.f) begin $error("cmp_f exp %0d got %0d", x.f, cmp_f); errors++; end
        if (big_sector !== x.sector) begin
          $error("big_sector exp %0d got %0d", x.sector, big_sector); errors++;
        end
        if (small_region !== x.region) begin
          $error("small_region exp %0d got %0d", x.region, small_region); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    if (idx == CFG_SWITCH_PERIOD) period_top = val;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || start || expected_cmps.size() > 0) @(posedge clk);
    // zero-bus words make no done, so give the pipeline time to empty
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic add_random_words(input int n);
    ref_word_t w;
    int shft;
    for (int i = 0; i < n; i++) begin
      shft = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
      w.alpha = $signed(16'($urandom)) >>> shft;
      w.beta = $signed(16'($urandom)) >>> shft;
      case ($urandom_range(0, 9))
        0:       w.udc = '0;
        1:       w.udc = 15'h7fff;
        2, 3:    w.udc = 15'($urandom_range(1, 64));
        default: w.udc = 15'($urandom_range(1, 32767)) >> $urandom_range(0, 14);
      endcase
      if (w.udc == 0 && $urandom_range(0, 1)) w.udc = 15'd1;
      pending_words.push_back(w);
    end
  endtask

  initial begin
    logic signed [15:0] dir_a[12] = '{16'sd0, 16'sd20000, -16'sd20000, 16'sd32767, -16'sd32768,
                                      16'sd0, 16'sd0, 16'sd10000, -16'sd10000, 16'sd10000,
                                      -16'sd10000, 16'sd1};
    logic signed [15:0] dir_b[12] = '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
                                      16'sd20000, -16'sd20000, 16'sd17320, 16'sd17320,
                                      -16'sd17320, -16'sd17320, -16'sd1};
    logic [15:0] periods[5] = '{16'd1, 16'd65535, 16'd5000, 16'd0, 16'd0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: zero bus, zero vector, sector edges and extremes at low and high bus
    for (int i = 0; i < 12; i++) begin
      pending_words.push_back('{dir_a[i], dir_b[i], 15'd30000});
      pending_words.push_back('{dir_a[i], dir_b[i], 15'd1});
    end
    pending_words.push_back('{16'sd1000, 16'sd1000, 15'd0});
    drain();

    periods[3] = 16'($urandom_range(1, 65535));
    periods[4] = 16'($urandom_range(1, 65535));
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_SAMPLE_PERIOD, (p == 0) ? 16'd1 : (p == 1) ? 16'hffff
                                                             : 16'($urandom_range(1, 65535)));
      write_reg(CFG_SWITCH_PERIOD, periods[p]);
      no_gaps = (p == 2);
      add_random_words(350);
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: three_level_svpwm_compare_gen_core.f
src/svpwm3_pkg.sv
src/svpwm3_div.sv
src/three_level_svpwm_compare_gen_core.sv
tb/tb_three_level_svpwm_compare_gen_core.sv
